FILE: design/vdns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdns_pkg: shared types and constants for the nearest-vector search block
// Field widths, metric and register codes, and the result record.
// ----------------------------------------------------------------------------
package vdns_pkg;

	localparam int DIST_W     = 47;
	localparam int IDX_W      = 16;
	localparam int MODE_W     = 2;
	localparam int DIM_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// result queue
	localparam int RES_DEPTH  = 8;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		METRIC_IP   = 2'd0,
		METRIC_L2   = 2'd1,
		METRIC_L1   = 2'd2,
		METRIC_LINF = 2'd3
	} metric_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METRIC_MODE = 1'b0,
		REG_VECTOR_DIM  = 1'b1
	} cfg_reg_t;

	localparam metric_t           METRIC_RESET = METRIC_L2;
	localparam logic [DIM_W-1:0]  DIM_RESET    = 11'd128;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  cand_index;
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
		logic              set_done;
	} result_t;

endpackage
`default_nettype wire

FILE: design/vdns_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdns channel interfaces
// Valid/ready channels for element items and for search results.
// ----------------------------------------------------------------------------
interface vdns_req_if #(
	parameter int ELEM_W = 16
) ();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [ELEM_W-1:0] elem_value;
	logic                     last_candidate;

	modport source (output valid, req_type, elem_value, last_candidate, input ready);
	modport sink   (input valid, req_type, elem_value, last_candidate, output ready);
endinterface

interface vdns_res_if ();
	logic                                valid;
	logic                                ready;
	logic signed [vdns_pkg::DIST_W-1:0]  distance;
	logic        [vdns_pkg::IDX_W-1:0]   cand_index;
	logic        [vdns_pkg::IDX_W-1:0]   best_index;
	logic signed [vdns_pkg::DIST_W-1:0]  best_distance;
	logic                                set_done;

	modport source (output valid, distance, cand_index, best_index, best_distance, set_done,
		input ready);
	modport sink   (input valid, distance, cand_index, best_index, best_distance, set_done,
		output ready);
endinterface
`default_nettype wire

FILE: design/vdns_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdns_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vdns_ram #(
	parameter int   WIDTH = 16,
	parameter int   DEPTH = 1024,
	localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: design/vdns_res_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vdns_res_fifo: result queue
// Small register FIFO between the search pipeline and the result channel.
// ----------------------------------------------------------------------------
module vdns_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vdns_pkg::result_t  wdata,
	input  logic               pop,
	output vdns_pkg::result_t  rdata,
	output logic               valid
);

	localparam int PW = vdns_pkg::RES_PTR_W;
	localparam int CW = vdns_pkg::RES_CNT_W;

	vdns_pkg::result_t mem_q [vdns_pkg::RES_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign valid = (cnt_q != '0);

endmodule
`default_nettype wire

FILE: design/vector_distance_nearest_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_distance_nearest_search: streaming brute-force nearest vector search
// Query store, per-candidate distance accumulation and running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   req carries element items. req_type 0 loads the next query element into
//   the query store, req_type 1 streams the next element of a candidate.
//   After vector_dim candidate elements one result goes out on res: the
//   candidate's distance and index plus the nearest candidate so far in the
//   set; last_candidate on that final element closes the set.
//   cfg_we/cfg_index/cfg_data write metric_mode (0) and vector_dim (1); write
//   only while the block is idle.
// Rate: one element item per cycle while req.ready is high. The datapath is a fixed
//   pipeline (RAM read, abs difference, multiply, accumulate, minimum search);
//   the result of a vector's final candidate element is pushed into the result
//   queue after the minimum search, and res.valid follows from the queue's count.
// Stalls: results queue in an eight-entry FIFO. req.ready drops only while
//   eight results are queued or in flight, i.e. when res is held off long
//   enough; the pipeline itself never stalls.
// Reset: registers return to metric L2, dimension 128, empty set. The query
//   store is not cleared; load a full query before streaming candidates.
// ----------------------------------------------------------------------------
module vector_distance_nearest_search #(
	parameter int MAX_DIM        = 1024,
	parameter int MAX_CANDIDATES = 65536,
	parameter int ELEM_WIDTH     = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vdns_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vdns_pkg::CFG_DATA_W-1:0]    cfg_data,
	vdns_req_if.sink                           req,
	vdns_res_if.source                         res
);

	localparam int EW    = ELEM_WIDTH;
	localparam int EW1   = ELEM_WIDTH + 1;
	localparam int MW    = ELEM_WIDTH + 2;          // multiplier operand width
	localparam int PRW   = 2 * MW;                  // product width
	localparam int DW    = vdns_pkg::DIST_W;
	localparam int IW    = vdns_pkg::IDX_W;
	localparam int VW    = vdns_pkg::DIM_W;
	localparam int MDW   = vdns_pkg::MODE_W;
	localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DCW   = $clog2(MAX_DIM + 1);
	localparam int CNT_W = (DCW > VW) ? DCW : VW;  // wide enough for dim compares
	localparam int CW    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int PCW   = vdns_pkg::RES_CNT_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	vdns_pkg::metric_t metric_q;
	logic [VW-1:0]     vdim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= vdns_pkg::METRIC_RESET;
			vdim_q   <= vdns_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (vdns_pkg::cfg_reg_t'(cfg_index))
				vdns_pkg::REG_METRIC_MODE: metric_q <= vdns_pkg::metric_t'(cfg_data[MDW-1:0]);
				vdns_pkg::REG_VECTOR_DIM:  vdim_q   <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// Effective dimension: zero acts as one, clamp at MAX_DIM.
	logic [CNT_W-1:0] dim_eff;

	always_comb begin
		if (vdim_q == '0) begin
			dim_eff = CNT_W'(1);
		end else if (CNT_W'(vdim_q) > CNT_W'(MAX_DIM)) begin
			dim_eff = CNT_W'(MAX_DIM);
		end else begin
			dim_eff = CNT_W'(vdim_q);
		end
	end

	// ------------------------------------------------------------------
	// Position counters (query load and candidate element)
	// ------------------------------------------------------------------
	logic [AW-1:0]    qlc_q;
	logic [AW-1:0]    elem_cnt_q;
	logic [AW-1:0]    load_addr;
	logic [AW-1:0]    qlc_d;
	logic [AW-1:0]    elem_cnt_d;
	logic [CNT_W-1:0] load_nxt;
	logic [CNT_W-1:0] elem_nxt;
	logic             vec_last;

	always_comb begin
		// a shrunk dimension restarts the load position at zero
		load_addr  = (CNT_W'(qlc_q) >= dim_eff) ? '0 : qlc_q;
		load_nxt   = CNT_W'(load_addr) + CNT_W'(1);
		qlc_d      = (load_nxt >= dim_eff) ? '0 : load_nxt[AW-1:0];
		// next count at or past the dimension ends the vector on this element
		elem_nxt   = CNT_W'(elem_cnt_q) + CNT_W'(1);
		vec_last   = (elem_nxt >= dim_eff);
		elem_cnt_d = vec_last ? '0 : elem_nxt[AW-1:0];
	end

	logic req_xfer;
	logic load_xfer;
	logic cand_xfer;
	logic res_xfer;
	logic [PCW-1:0] pend_q;       // results in the pipeline or in the queue

	assign req_xfer  = req.valid & req.ready;
	assign load_xfer = req_xfer & ~req.req_type;
	assign cand_xfer = req_xfer & req.req_type;
	assign res_xfer  = res.valid & res.ready;
	assign req.ready = (pend_q < PCW'(vdns_pkg::RES_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlc_q      <= '0;
			elem_cnt_q <= '0;
			pend_q     <= '0;
		end else begin
			if (load_xfer) begin
				qlc_q <= qlc_d;
			end
			if (cand_xfer) begin
				elem_cnt_q <= elem_cnt_d;
			end
			pend_q <= pend_q + PCW'(cand_xfer & vec_last) - PCW'(res_xfer);
		end
	end

	// ------------------------------------------------------------------
	// Query store. Read address is the candidate position, so the query
	// element arrives with the candidate element in stage 1.
	// ------------------------------------------------------------------
	logic [EW-1:0] q_rd;

	vdns_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_DIM)
	) u_query_ram (
		.clk   (clk),
		.we    (load_xfer),
		.waddr (load_addr),
		.wdata (req.elem_value),
		.raddr (elem_cnt_q),
		.rdata (q_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: candidate element registered, query element from RAM
	// ------------------------------------------------------------------
	logic                 v_s1;
	logic                 last_s1;
	logic                 done_s1;
	vdns_pkg::metric_t    mode_s1;
	logic signed [EW-1:0] c_s1;
	logic signed [EW-1:0] q_s1;
	logic signed [EW:0]   diff_s1;
	logic [EW:0]          ad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cand_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_xfer) begin
			c_s1    <= req.elem_value;
			last_s1 <= vec_last;
			done_s1 <= req.last_candidate;
			mode_s1 <= metric_q;
		end
	end

	always_comb begin
		q_s1    = $signed(q_rd);
		diff_s1 = EW1'(q_s1) - EW1'(c_s1);
		ad_s1   = diff_s1[EW] ? EW1'(-diff_s1) : EW1'(diff_s1);
	end

	// ------------------------------------------------------------------
	// Stage 2: operands for the multiplier, term selection
	// ------------------------------------------------------------------
	logic                  v_s2;
	logic                  last_s2;
	logic                  done_s2;
	vdns_pkg::metric_t     mode_s2;
	logic signed [EW-1:0]  q_s2;
	logic signed [EW-1:0]  c_s2;
	logic [EW:0]           ad_s2;
	logic signed [MW-1:0]  op_a;
	logic signed [MW-1:0]  op_b;
	logic signed [PRW-1:0] prod_s2;
	logic [DW-1:0]         term_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			q_s2    <= q_s1;
			c_s2    <= c_s1;
			ad_s2   <= ad_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;
			mode_s2 <= mode_s1;
		end
	end

	always_comb begin
		// inner product multiplies signed elements, L2 squares |q-c|
		if (mode_s2 == vdns_pkg::METRIC_IP) begin
			op_a = MW'(q_s2);
			op_b = MW'(c_s2);
		end else begin
			op_a = $signed(MW'(ad_s2));
			op_b = $signed(MW'(ad_s2));
		end
		prod_s2 = op_a * op_b;
		case (mode_s2) inside
			vdns_pkg::METRIC_IP, vdns_pkg::METRIC_L2: term_s2 = DW'(prod_s2);
			default:                                  term_s2 = DW'(ad_s2);
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 3: accumulate (sum, or running max for L-infinity)
	// ------------------------------------------------------------------
	logic              v_s3;
	logic              last_s3;
	logic              done_s3;
	vdns_pkg::metric_t mode_s3;
	logic [DW-1:0]     term_s3;
	logic [DW-1:0]     acc_q;
	logic [DW-1:0]     acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			term_s3 <= term_s2;
			last_s3 <= last_s2;
			done_s3 <= done_s2;
			mode_s3 <= mode_s2;
		end
	end

	always_comb begin
		if (mode_s3 == vdns_pkg::METRIC_LINF) begin
			acc_nxt = ($signed(acc_q) < $signed(term_s3)) ? term_s3 : acc_q;
		end else begin
			acc_nxt = acc_q + term_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: finished distance against the running nearest
	// ------------------------------------------------------------------
	logic          v_s4;
	logic          done_s4;
	logic [DW-1:0] dist_s4;
	logic [CW-1:0] cand_cnt_q;
	logic [DW-1:0] best_dist_q;
	logic [CW-1:0] best_idx_q;
	logic          best_seen_q;
	logic          better;
	logic [DW-1:0] new_best_dist;
	logic [CW-1:0] new_best_idx;
	logic [CW-1:0] cand_cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			v_s4  <= 1'b0;
		end else begin
			v_s4 <= v_s3 & last_s3;
			if (v_s3) begin
				acc_q <= last_s3 ? '0 : acc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && last_s3) begin
			dist_s4 <= acc_nxt;
			done_s4 <= done_s3;
		end
	end

	always_comb begin
		// strict less-than: the earliest index keeps a tie
		better        = !best_seen_q || ($signed(dist_s4) < $signed(best_dist_q));
		new_best_dist = better ? dist_s4 : best_dist_q;
		new_best_idx  = better ? cand_cnt_q : best_idx_q;
		cand_cnt_inc  = (cand_cnt_q == CW'(MAX_CANDIDATES - 1)) ? '0 : cand_cnt_q + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_cnt_q  <= '0;
			best_dist_q <= '0;
			best_idx_q  <= '0;
			best_seen_q <= 1'b0;
		end else if (v_s4) begin
			if (done_s4) begin
				cand_cnt_q  <= '0;
				best_dist_q <= '0;
				best_idx_q  <= '0;
				best_seen_q <= 1'b0;
			end else begin
				cand_cnt_q  <= cand_cnt_inc;
				best_dist_q <= new_best_dist;
				best_idx_q  <= new_best_idx;
				best_seen_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue and output channel
	// ------------------------------------------------------------------
	vdns_pkg::result_t res_wdata;
	vdns_pkg::result_t res_rdata;

	always_comb begin
		res_wdata.distance      = dist_s4;
		res_wdata.cand_index    = IW'(cand_cnt_q);
		res_wdata.best_index    = IW'(new_best_idx);
		res_wdata.best_distance = new_best_dist;
		res_wdata.set_done      = done_s4;
	end

	vdns_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s4),
		.wdata  (res_wdata),
		.pop    (res_xfer),
		.rdata  (res_rdata),
		.valid  (res.valid)
	);

	assign res.distance      = $signed(res_rdata.distance);
	assign res.cand_index    = res_rdata.cand_index;
	assign res.best_index    = res_rdata.best_index;
	assign res.best_distance = $signed(res_rdata.best_distance);
	assign res.set_done      = res_rdata.set_done;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PCW'(vdns_pkg::RES_DEPTH))
		else $error("pending result count above queue depth");

	a_res_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (pend_q != '0))
		else $error("result offered with no pending result counted");

	a_set_close: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && done_s4) |=> (cand_cnt_q == '0 && !best_seen_q))
		else $error("set not cleared after closing result");

	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(elem_cnt_q) < CNT_W'(MAX_DIM))
		else $error("candidate position outside query store");

endmodule
`default_nettype wire
